// ===== hdl/lzss_decompressor_core_assert.svh =====
// Assertion macros shared by the decompressor RTL.
`ifndef LZSS_DECOMPRESSOR_CORE_ASSERT_SVH
`define LZSS_DECOMPRESSOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define LZSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define LZSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lzss_pkg.sv =====
`timescale 1ns / 1ps
// Types and format constants of the LZSS decompressor.
package lzss_pkg;

    typedef logic [7:0] t_byte;

    // Decode phase; the copy phase runs a back-reference out of the window.
    typedef enum logic [1:0] {
        PH_FLAG   = 2'd0,
        PH_ITEM   = 2'd1,
        PH_SECOND = 2'd2,
        PH_COPY   = 2'd3
    } t_phase;

    localparam int          LEFT_W    = 5;
    localparam int          MAX_MATCH = 18;
    localparam logic [4:0]  MIN_MATCH = 5'd3;
    localparam t_byte       FILL_BYTE = 8'h20;

endpackage

// ===== hdl/lzss_in_if.sv =====
`timescale 1ns / 1ps
// Compressed-byte stream channel.
interface lzss_in_if;
    import lzss_pkg::*;

    logic  valid;
    logic  ready;
    t_byte in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== hdl/lzss_out_if.sv =====
`timescale 1ns / 1ps
// Decompressed-byte stream channel.
interface lzss_out_if;
    import lzss_pkg::*;

    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== hdl/lzss_decompressor_core.sv =====
`timescale 1ns / 1ps
// A literal word shows on the output in the cycle after it is accepted; the first copied
// word of a reference goes through the copy phase, read register and output register.
// Flag, literal and reference words are taken while the output has room; a reference of
// length L (3..18) holds off the input during its copy, one window read per output word.
// Reset (i_rst_n, synchronous, active low): phase to flag, write position to 4078; no
// clearing pass, a fill count makes never-written window entries read as 0x20.
`include "lzss_decompressor_core_assert.svh"

module lzss_decompressor_core #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lzss_in_if.sink    i_in,
    lzss_out_if.source o_out
);
    import lzss_pkg::*;

    localparam int AW          = $clog2(WINDOW_DEPTH);
    localparam int WRITE_START = WINDOW_DEPTH - MAX_MATCH;

    // Window memory: one write port, one registered read port.
    t_byte r_win [WINDOW_DEPTH];
    t_byte r_mem_q;

    // Decode control
    t_phase            r_phase, n_phase;
    logic [7:0]        r_flags, n_flags;
    logic [2:0]        r_cnt, n_cnt;
    t_byte             r_low, n_low;
    logic [AW-1:0]     r_wp, n_wp;
    logic [AW-1:0]     r_cp, n_cp;
    logic [LEFT_W-1:0] r_left, n_left;
    logic [AW:0]       r_fill, n_fill;

    // Read in flight: forwarding and fill-count result travel with it
    logic  r_pend, n_pend;
    logic  r_pend_last, n_pend_last;
    logic  r_fwd, n_fwd;
    t_byte r_fwd_data, n_fwd_data;
    logic  r_fresh, n_fresh;

    // Skid word for when the output is stalled as read data lands
    logic  r_hold_valid, n_hold_valid;
    t_byte r_hold_byte, n_hold_byte;
    logic  r_hold_last, n_hold_last;

    // Output register
    logic  r_out_valid, n_out_valid;
    t_byte r_out_byte, n_out_byte;
    logic  r_out_last, n_out_last;

    // Datapath strobes
    logic          out_free;
    logic          in_ready;
    logic          acc;
    logic          lit;
    logic          second;
    logic          issue;
    logic          copy_done;
    logic          wr_en;
    t_byte         wr_data;
    t_byte         arr_byte;
    logic [AW-1:0] rel_pos;

    assign out_free  = !r_out_valid || o_out.ready;
    // Take a word only outside a copy and with room in the output register.
    assign in_ready  = (r_phase != PH_COPY) && out_free;
    assign acc       = i_in.valid && in_ready;
    assign lit       = acc && (r_phase == PH_ITEM) && r_flags[0];
    assign second    = acc && (r_phase == PH_SECOND);
    // Issue the next copy read unless the landing word would have nowhere to go.
    assign issue     = (r_phase == PH_COPY) && (r_left != '0) && !r_hold_valid
                       && !(r_pend && !out_free);
    assign copy_done = (r_phase == PH_COPY) && (r_left == '0) && !r_pend && !r_hold_valid;

    // Landing read data: forwarded write, stored entry, or the fill byte if never written.
    assign arr_byte  = r_fwd ? r_fwd_data : (r_fresh ? r_mem_q : FILL_BYTE);

    assign wr_en     = lit || r_pend;
    assign wr_data   = lit ? i_in.in_byte : arr_byte;

    // Writes run in address order from the start position, so an entry holds data
    // exactly when its distance from that start is below the fill count.
    assign rel_pos   = r_cp - AW'(WRITE_START);

    assign i_in.ready     = in_ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.run_last = r_out_last;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_FLAG: begin
                if (acc) n_phase = PH_ITEM;
            end
            PH_ITEM: begin
                if (acc) begin
                    if (r_flags[0]) n_phase = (r_cnt == 3'd7) ? PH_FLAG : PH_ITEM;
                    else            n_phase = PH_SECOND;
                end
            end
            PH_SECOND: begin
                if (acc) n_phase = PH_COPY;
            end
            PH_COPY: begin
                // The flag count was already advanced when the reference closed.
                if (copy_done) n_phase = (r_cnt == 3'd0) ? PH_FLAG : PH_ITEM;
            end
            default: n_phase = PH_FLAG;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_flags      = r_flags;
        n_cnt        = r_cnt;
        n_low        = r_low;
        n_wp         = r_wp;
        n_cp         = r_cp;
        n_left       = r_left;
        n_fill       = r_fill;
        n_pend       = issue;
        n_pend_last  = r_pend_last;
        n_fwd        = r_fwd;
        n_fwd_data   = r_fwd_data;
        n_fresh      = r_fresh;
        n_hold_valid = r_hold_valid;
        n_hold_byte  = r_hold_byte;
        n_hold_last  = r_hold_last;
        n_out_valid  = r_out_valid;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;

        if (acc && (r_phase == PH_FLAG)) begin
            n_flags = i_in.in_byte;
            n_cnt   = 3'd0;
        end
        if (acc && (r_phase == PH_ITEM) && !r_flags[0]) begin
            n_low = i_in.in_byte;
        end
        // Consume one control bit per literal or finished reference.
        if (lit || second) begin
            n_flags = r_flags >> 1;
            n_cnt   = r_cnt + 3'd1;
        end
        if (second) begin
            n_cp   = AW'({i_in.in_byte[7:4], r_low});
            n_left = MIN_MATCH + LEFT_W'(i_in.in_byte[3:0]);
        end

        if (issue) begin
            n_cp        = r_cp + AW'(1);
            n_left      = r_left - LEFT_W'(1);
            n_pend_last = (r_left == LEFT_W'(1));
            // Same-entry write this cycle: the memory would return the old byte.
            n_fwd       = wr_en && (r_wp == r_cp);
            n_fwd_data  = wr_data;
            n_fresh     = {1'b0, rel_pos} < r_fill;
        end

        if (wr_en) begin
            n_wp = r_wp + AW'(1);
            if (r_fill < (AW+1)'(WINDOW_DEPTH)) n_fill = r_fill + (AW+1)'(1);
        end

        if (out_free) begin
            if (r_hold_valid) begin
                n_out_valid  = 1'b1;
                n_out_byte   = r_hold_byte;
                n_out_last   = r_hold_last;
                n_hold_valid = 1'b0;
            end else if (r_pend) begin
                n_out_valid = 1'b1;
                n_out_byte  = arr_byte;
                n_out_last  = r_pend_last;
            end else if (lit) begin
                n_out_valid = 1'b1;
                n_out_byte  = i_in.in_byte;
                n_out_last  = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (r_pend) begin
            // Park the landing word until the output drains.
            n_hold_valid = 1'b1;
            n_hold_byte  = arr_byte;
            n_hold_last  = r_pend_last;
        end
    end

    // Window memory
    always_ff @(posedge i_clk) begin
        if (wr_en) r_win[r_wp] <= wr_data;
        if (issue) r_mem_q <= r_win[r_cp];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_FLAG;
            r_flags      <= '0;
            r_cnt        <= '0;
            r_low        <= '0;
            r_wp         <= AW'(WRITE_START);
            r_cp         <= '0;
            r_left       <= '0;
            r_fill       <= '0;
            r_pend       <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_flags      <= n_flags;
            r_cnt        <= n_cnt;
            r_low        <= n_low;
            r_wp         <= n_wp;
            r_cp         <= n_cp;
            r_left       <= n_left;
            r_fill       <= n_fill;
            r_pend       <= n_pend;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pend_last <= n_pend_last;
        r_fwd       <= n_fwd;
        r_fwd_data  <= n_fwd_data;
        r_fresh     <= n_fresh;
        r_hold_byte <= n_hold_byte;
        r_hold_last <= n_hold_last;
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
    end

    `LZSS_ASSERT_NOW(a_no_input_in_copy, r_phase == PH_COPY, !i_in.ready, "input taken during copy")
    `LZSS_ASSERT_NOW(a_skid_excl, r_hold_valid, !r_pend, "skid word and read in flight together")
    `LZSS_ASSERT_NOW(a_idle_clean, r_phase != PH_COPY, (r_left == '0) && !r_pend && !r_hold_valid, "copy state left behind")
    `LZSS_ASSERT_NEXT(a_copy_len, second, (r_left >= MIN_MATCH) && (r_left <= LEFT_W'(MAX_MATCH)), "bad copy length")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the LZSS decompressor core: random and directed streams.
module testbench;
    import lzss_pkg::*;

    localparam int          CLK_HALF   = 6;
    localparam int unsigned CYCLE_CAP  = 400000;
    localparam int unsigned WORD_GOAL  = 80;
    localparam int unsigned DRAIN_WAIT = 30;
    localparam int unsigned HOLD_AT    = 100;
    localparam int unsigned HOLD_LEN   = 400;

    // Tracks the decoder state and holds the decompressed words still owed.
    class lzss_stream_tracker;
        t_phase      step;
        t_byte       flags;
        int unsigned flags_used;
        t_byte       ref_low;
        t_byte       history [4096];
        logic [11:0] put_pos;
        t_byte       owed_byte [$];
        bit          owed_last [$];
        int unsigned errors;

        function new();
            step       = PH_FLAG;
            flags      = '0;
            flags_used = 0;
            ref_low    = '0;
            put_pos    = 12'(4096 - MAX_MATCH);
            errors     = 0;
            foreach (history[i]) history[i] = FILL_BYTE;
        endfunction

        function void emit(t_byte v, bit last);
            owed_byte = {owed_byte, v};
            owed_last = {owed_last, last};
            history[put_pos] = v;
            put_pos++;
        endfunction

        function void next_flag();
            flags = flags >> 1;
            if (flags_used >= 7) begin
                flags_used = 0;
                step       = PH_FLAG;
            end else begin
                flags_used++;
                step = PH_ITEM;
            end
        endfunction

        // Note one accepted compressed word and queue the words it decodes to.
        function void take_word(t_byte b);
            logic [11:0] src;
            int unsigned run_len;
            case (step)
                PH_ITEM: begin
                    if (flags[0]) begin
                        emit(b, 1'b1);
                        next_flag();
                    end else begin
                        ref_low = b;
                        step    = PH_SECOND;
                    end
                end
                PH_SECOND: begin
                    src     = {b[7:4], ref_low};
                    run_len = MIN_MATCH + b[3:0];
                    // Read and write back one word at a time so overlaps see fresh data.
                    for (int k = 0; k < run_len; k++) begin
                        emit(history[src], k == run_len - 1);
                        src++;
                    end
                    next_flag();
                end
                default: begin
                    flags      = b;
                    flags_used = 0;
                    step       = PH_ITEM;
                end
            endcase
        endfunction

        // Compare one accepted output word with the oldest owed word.
        function void match_word(t_byte got_byte, logic got_last);
            t_byte want_byte;
            bit    want_last;
            if (owed_byte.size() == 0) begin
                $display("%0t: unexpected word: expected none got byte %h last %b", $time,
                         got_byte, got_last);
                errors++;
                return;
            end
            want_byte = owed_byte.pop_front();
            want_last = owed_last.pop_front();
            if (got_byte !== want_byte) begin
                $display("%0t: out_byte mismatch: expected %h got %h", $time, want_byte,
                         got_byte);
                errors++;
            end
            if (got_last !== want_last) begin
                $display("%0t: run_last mismatch: expected %b got %b", $time, want_last,
                         got_last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    lzss_in_if  in_ch ();
    lzss_out_if out_ch ();

    lzss_decompressor_core #(
        .WINDOW_DEPTH(4096)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    lzss_stream_tracker tracker;
    bit                 gapless;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Offer one compressed word and hold it until the block takes it.
    task automatic send_word(input t_byte b);
        int unsigned gap;
        gap = gapless ? 0 : pick_gap();
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        tracker.take_word(b);
    endtask

    // Output side: check accepted words, stall at random, and hold off once for a long
    // stretch so the block backs up into its input.
    initial begin : drain
        int unsigned stall_left;
        int unsigned seen;
        bit          held_off;
        stall_left = 0;
        seen       = 0;
        held_off   = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
                continue;
            end
            if (out_ch.valid && out_ch.ready) begin
                tracker.match_word(out_ch.out_byte, out_ch.run_last);
                seen++;
            end
            if (!held_off && seen >= HOLD_AT) begin
                held_off   = 1'b1;
                stall_left = HOLD_LEN;
            end else if (stall_left == 0 && $urandom_range(0, 99) < 8) begin
                stall_left = pick_gap();
            end
            if (stall_left != 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_CAP) begin
                $display("lzss_decompressor_core verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_byte       opening [];
        int unsigned sent;
        t_byte       flags;
        logic [11:0] src;
        logic [3:0]  len_nib;

        // Literal extremes fill a whole flag; then a flag of four references and four
        // literals: a read of never-written fill, a copy that wraps the write position,
        // an overlapping copy of the word just written, and a read that wraps the window.
        opening = {
            8'hFF, 8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F, 8'hFE,
            8'hF0, 8'h00, 8'h00, 8'hEE, 8'hFF, 8'h0A, 8'h0F, 8'hFF, 8'hF7,
            8'h20, 8'h55, 8'hAA, 8'h0F
        };
        tracker = new();
        gapless = 1'b0;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening[i]) send_word(opening[i]);

        // Mostly well-formed flag groups; a stray word now and then shifts the framing.
        sent = 0;
        while (sent < WORD_GOAL) begin
            gapless = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) begin
                send_word(t_byte'($urandom_range(0, 255)));
                sent++;
            end else begin
                flags = t_byte'($urandom_range(0, 255));
                send_word(flags);
                sent++;
                for (int i = 0; i < 8; i++) begin
                    if (flags[i]) begin
                        send_word(t_byte'($urandom_range(0, 255)));
                        sent++;
                    end else begin
                        // Favor recent history, so overlaps and real matches show up.
                        if ($urandom_range(0, 3) != 0)
                            src = tracker.put_pos - 12'($urandom_range(1, 40));
                        else
                            src = 12'($urandom_range(0, 4095));
                        len_nib = 4'($urandom_range(0, 15));
                        send_word(src[7:0]);
                        send_word({src[11:8], len_nib});
                        sent += 2;
                    end
                end
            end
        end
        in_ch.valid <= 1'b0;

        while (tracker.owed_byte.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (tracker.errors == 0 && tracker.owed_byte.size() == 0) begin
            $display("lzss_decompressor_core verification clean");
        end else begin
            $display("lzss_decompressor_core verification failed");
        end
        $finish;
    end

endmodule
